/* rtl/core/psts_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic priority task scheduler - shared definitions
// Command and status codes, the broadcast command to the task cells and the
// running-best record that travels along the cell chain.
// ----------------------------------------------------------------------------
package psts_pkg;

	// Table size limits
	localparam int unsigned MAX_TASKS_DEF = 16;
	localparam int unsigned IDX_MAX_W     = 6;     // enough for up to 64 entries

	// Field widths fixed by the item format
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned TARGET_W = 4;
	localparam int unsigned TIME16_W = 16;
	localparam int unsigned PRIO_W   = 8;
	localparam int unsigned TICK_W   = 10;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CHOSEN_W = 4;
	localparam int unsigned SYSTIM_W = 32;

	localparam logic [TICK_W-1:0]   TICK_RESET  = TICK_W'(1);
	localparam logic [PRIO_W-1:0]   PRIO_NEVER  = 8'd255;
	localparam logic [TIME16_W-1:0] ELAPSED_MAX = 16'hFFFF;

	// Item action codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK   = 3'd0,
		ACT_SCHED  = 3'd1,
		ACT_ADD    = 3'd2,
		ACT_SUSP   = 3'd3,
		ACT_RESUME = 3'd4
	} act_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_SWEEP = 2'd1,
		S_PUT   = 2'd2
	} state_t;

	// Operations broadcast to every cell
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_TICK   = 3'd1,
		OP_ADD    = 3'd2,
		OP_SUSP   = 3'd3,
		OP_RESUME = 3'd4,
		OP_CLEAR  = 3'd5
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [IDX_MAX_W-1:0]  sel;
		logic [TICK_W-1:0]     tick;
		logic [TIME16_W-1:0]   period;
		logic [TIME16_W-1:0]   delay;
		logic [PRIO_W-1:0]     prio;
	} cell_cmd_t;

	// Best candidate seen so far along the chain
	typedef struct packed {
		logic                  found;
		logic [PRIO_W-1:0]     prio;
		logic [IDX_MAX_W-1:0]  idx;
	} best_t;

endpackage

/* rtl/core/psts_in_if.sv */
// ----------------------------------------------------------------------------
// Scheduler command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface psts_in_if;
	logic                          valid;
	logic                          ready;
	logic [psts_pkg::ACTION_W-1:0] action;
	logic [psts_pkg::TARGET_W-1:0] target_task;
	logic [psts_pkg::TIME16_W-1:0] period_ms;
	logic [psts_pkg::TIME16_W-1:0] start_delay_ms;
	logic [psts_pkg::PRIO_W-1:0]   task_priority;

	modport source (output valid, action, target_task, period_ms, start_delay_ms,
		task_priority, input ready);
	modport sink (input valid, action, target_task, period_ms, start_delay_ms,
		task_priority, output ready);
endinterface

/* rtl/core/psts_out_if.sv */
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface psts_out_if;
	logic                          valid;
	logic                          ready;
	logic [psts_pkg::STATUS_W-1:0] status;
	logic [psts_pkg::CHOSEN_W-1:0] chosen_task;
	logic [psts_pkg::SYSTIM_W-1:0] system_time;

	modport source (output valid, status, chosen_task, system_time, input ready);
	modport sink (input valid, status, chosen_task, system_time, output ready);
endinterface

/* rtl/core/psts_cell.sv */
// ----------------------------------------------------------------------------
// Scheduler task cell
// Holds one task entry, applies the broadcast command and passes the running
// best due task on to its neighbour through a register every cycle.
// ----------------------------------------------------------------------------
module psts_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psts_pkg::cell_cmd_t cmd,
	input  psts_pkg::best_t     best_in,
	output psts_pkg::best_t     best_out,
	output logic                used
);
	import psts_pkg::*;

	localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

	logic                used_q;
	logic                susp_q;
	logic [TIME16_W-1:0] period_q;
	logic [TIME16_W-1:0] elapsed_q;
	logic [PRIO_W-1:0]   prio_q;
	best_t               best_q;

	logic                hit;
	logic                ready_task;
	logic [TIME16_W:0]   elapsed_sum;
	logic [TIME16_W-1:0] elapsed_tick;
	logic [TIME16_W-1:0] elapsed_init;
	logic                cand;
	logic                take;

	assign hit        = (cmd.sel == MY_IDX);
	assign ready_task = used_q && !susp_q;

	// Saturating timer advance
	assign elapsed_sum  = {1'b0, elapsed_q} + (TIME16_W+1)'(cmd.tick);
	assign elapsed_tick = elapsed_sum[TIME16_W] ? ELAPSED_MAX : elapsed_sum[TIME16_W-1:0];

	// Preset from start delay
	assign elapsed_init = (cmd.delay < cmd.period) ? (cmd.period - cmd.delay) : '0;

	// Candidate test and compare with the lower-index best
	assign cand = ready_task && (elapsed_q >= period_q) && (prio_q != PRIO_NEVER);
	assign take = cand && (!best_in.found || (prio_q < best_in.prio));

	// Entry payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_TICK: begin
				if (ready_task) begin
					elapsed_q <= elapsed_tick;
				end
			end
			OP_ADD: begin
				if (hit) begin
					period_q  <= cmd.period;
					prio_q    <= cmd.prio;
					elapsed_q <= elapsed_init;
				end
			end
			OP_CLEAR: begin
				if (hit) begin
					elapsed_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			susp_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_ADD: begin
					if (hit) begin
						used_q <= 1'b1;
						susp_q <= 1'b0;
					end
				end
				OP_SUSP: begin
					if (hit) begin
						susp_q <= 1'b1;
					end
				end
				OP_RESUME: begin
					if (hit) begin
						susp_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Pass the running best to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (take) begin
			best_q <= '{found: 1'b1, prio: prio_q, idx: MY_IDX};
		end else begin
			best_q <= best_in;
		end
	end

	assign best_out = best_q;
	assign used     = used_q;

endmodule

/* rtl/core/periodic_priority_task_scheduler.sv */
// ----------------------------------------------------------------------------
// Periodic priority task scheduler
// Table of periodic tasks held in a row of cells; picks the due, ready task of
// lowest priority number on a schedule item.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake    payload
//  cmd      in   valid/ready  action, target_task, period_ms, start_delay_ms,
//                             task_priority
//  rsp      out  valid/ready  status, chosen_task, system_time
//  cfg      in   cfg_we       cfg_wdata = tick_size_ms
//
//  Tick, add, suspend, resume and undefined items pass through S_PUT to the
//  output register. A schedule item first stays in S_SWEEP: the running best
//  ripples through the cell chain one register per cycle before the winner
//  is cleared. One item is worked on at a time; a new item is accepted once
//  the previous result has been moved into the output register, even while
//  that result still waits. Reset clears the table flags, the task count,
//  the system time and sets the tick size to 1; no clearing pass is needed.
//
module periodic_priority_task_scheduler #(
	parameter int unsigned MAX_TASKS = psts_pkg::MAX_TASKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	psts_in_if.sink                     cmd,
	psts_out_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [psts_pkg::TICK_W-1:0] cfg_wdata
);
	import psts_pkg::*;

	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    sweep_q;
	logic [CNT_W-1:0]    count_q;
	logic [SYSTIM_W-1:0] time_q;
	logic [TICK_W-1:0]   tick_q;
	status_t             res_status_q, res_status_d;
	logic [CHOSEN_W-1:0] res_chosen_q, res_chosen_d;
	logic                res_load;
	logic                out_load;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [CHOSEN_W-1:0] out_chosen_q;
	logic [SYSTIM_W-1:0] out_time_q;

	logic                 accept;
	logic                 tgt_ok;
	logic [IDX_MAX_W-1:0] tgt_ext;
	logic [IDX_MAX_W-1:0] count_ext;
	cell_cmd_t            cell_cmd;
	best_t                chain [MAX_TASKS+1];
	logic [MAX_TASKS-1:0] used_vec;
	best_t                final_best;

	assign accept     = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == S_IDLE);
	assign tgt_ext    = IDX_MAX_W'(cmd.target_task);
	assign count_ext  = IDX_MAX_W'(count_q);
	assign tgt_ok     = (int'(cmd.target_task) < MAX_TASKS) && used_vec[tgt_ext[IDX_W-1:0]];
	assign final_best = chain[MAX_TASKS];

	// Task cell chain
	assign chain[0] = '0;
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		psts_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cell_cmd),
			.best_in  (chain[i]),
			.best_out (chain[i+1]),
			.used     (used_vec[i])
		);
	end

	// Decode the item, drive the cells and form the result
	always_comb begin
		state_d         = state_q;
		cell_cmd.op     = OP_NONE;
		cell_cmd.sel    = '0;
		cell_cmd.tick   = tick_q;
		cell_cmd.period = cmd.period_ms;
		cell_cmd.delay  = cmd.start_delay_ms;
		cell_cmd.prio   = cmd.task_priority;
		res_status_d    = ST_OK;
		res_chosen_d    = '0;
		res_load        = 1'b0;
		out_load        = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					state_d  = S_PUT;
					case (cmd.action)
						ACT_TICK: begin
							cell_cmd.op = OP_TICK;
						end
						ACT_SCHED: begin
							res_load = 1'b0;
							state_d  = S_SWEEP;
						end
						ACT_ADD: begin
							if (int'(count_q) >= MAX_TASKS) begin
								res_status_d = ST_FULL;
							end else begin
								cell_cmd.op  = OP_ADD;
								cell_cmd.sel = count_ext;
								res_chosen_d = count_ext[CHOSEN_W-1:0];
							end
						end
						ACT_SUSP, ACT_RESUME: begin
							res_chosen_d = cmd.target_task;
							if (tgt_ok) begin
								cell_cmd.op  = (cmd.action == ACT_SUSP) ? OP_SUSP : OP_RESUME;
								cell_cmd.sel = tgt_ext;
							end else begin
								res_status_d = ST_BAD;
							end
						end
						default: begin
							res_status_d = ST_BAD;
						end
					endcase
				end
			end
			S_SWEEP: begin
				if (sweep_q == CNT_W'(MAX_TASKS)) begin
					res_load = 1'b1;
					state_d  = S_PUT;
					if (final_best.found) begin
						cell_cmd.op  = OP_CLEAR;
						cell_cmd.sel = final_best.idx;
						res_chosen_d = final_best.idx[CHOSEN_W-1:0];
					end else begin
						res_status_d = ST_NONE;
					end
				end
			end
			S_PUT: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state, task count, time base and tick size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sweep_q <= '0;
			count_q <= '0;
			time_q  <= '0;
			tick_q  <= TICK_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == S_SWEEP) begin
				sweep_q <= sweep_q + CNT_W'(1);
			end else begin
				sweep_q <= '0;
			end
			if (cell_cmd.op == OP_ADD) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cell_cmd.op == OP_TICK) begin
				time_q <= time_q + SYSTIM_W'(tick_q);
			end
			if (cfg_we) begin
				tick_q <= cfg_wdata;
			end
		end
	end

	// Hold the pending result
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= res_status_d;
			res_chosen_q <= res_chosen_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_chosen_q <= res_chosen_q;
			out_time_q   <= time_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.chosen_task = out_chosen_q;
	assign rsp.system_time = out_time_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_TASKS)
		else $error("task count beyond table size");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (int'(sweep_q) <= MAX_TASKS))
		else $error("sweep counter overran");

	a_sched_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.action == ACT_SCHED)) |=> (state_q == S_SWEEP))
		else $error("schedule item did not start a sweep");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (res_status_q == ST_FULL)) |-> (int'(count_q) == MAX_TASKS))
		else $error("table full reported with free entries");

endmodule
